### rtl/bltw_pkg.sv
// Shared types, register indexes and constants of the blitter word datapath.
// Used by bltw_word_logic and blitter_word_datapath; depends on nothing.
package bltw_pkg;

   // Size of the addressable memory in bytes; writes at or above it are suppressed
   localparam int unsigned MemoryBytes = 2097152;

   localparam int unsigned AddrWidth    = 24;
   localparam int unsigned WordWidth    = 16;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [2:0] {
      REG_CONTROL_ZERO    = 3'd0,
      REG_CONTROL_ONE     = 3'd1,
      REG_FIRST_WORD_MASK = 3'd2,
      REG_LAST_WORD_MASK  = 3'd3,
      REG_BLIT_SIZE       = 3'd4,
      REG_DEST_START      = 3'd5,
      REG_DEST_MODULO     = 3'd6
   } reg_index_type;

   // Input transaction
   typedef struct packed {
      logic [15:0] a_word;
      logic [15:0] b_word;
      logic [15:0] c_word;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [15:0] d_word;
      logic [23:0] dest_address;
      logic        write_enable;
      logic        last_word;
   } rsp_type;

   // Per-word control handed to the word logic
   typedef struct packed {
      logic [3:0]  a_shift;
      logic [3:0]  b_shift;
      logic        descending;
      logic [7:0]  minterm;
      logic [15:0] first_mask;
      logic [15:0] last_mask;
      logic        first_col;
      logic        last_col;
   } word_ctrl_type;

endpackage

### rtl/bltw_word_logic.sv
// Word logic of the blitter: A edge masking, A/B barrel shift with the previous
// word, and the three-input minterm. Purely combinational; uses bltw_pkg.
module bltw_word_logic (
   input  bltw_pkg::word_ctrl_type ctrl,
   input  logic [15:0]             a_word,
   input  logic [15:0]             b_word,
   input  logic [15:0]             c_word,
   input  logic [15:0]             prev_a,
   input  logic [15:0]             prev_b,
   output logic [15:0]             a_clipped,
   output logic [15:0]             d_word
);

   logic [15:0] a_shifted;
   logic [15:0] b_shifted;

   // Shift a fresh word together with the previous one on the same channel
   function automatic logic [15:0] shift_pair(input logic [15:0] fresh,
                                              input logic [15:0] old,
                                              input logic [3:0]  sh,
                                              input logic        desc);
      logic [31:0] joined;
      logic [4:0]  amount;
      begin
         if (desc) begin
            joined = {fresh, old};
            amount = 5'd16 - {1'b0, sh};
         end else begin
            joined = {old, fresh};
            amount = {1'b0, sh};
         end
         joined = joined >> amount;
         shift_pair = joined[15:0];
      end
   endfunction

   // Edge masks on A
   always_comb begin
      a_clipped = a_word;
      if (ctrl.first_col) a_clipped = a_clipped & ctrl.first_mask;
      if (ctrl.last_col)  a_clipped = a_clipped & ctrl.last_mask;
   end

   assign a_shifted = shift_pair(a_clipped, prev_a, ctrl.a_shift, ctrl.descending);
   assign b_shifted = shift_pair(b_word, prev_b, ctrl.b_shift, ctrl.descending);

   // Minterm: bit i of the function selects the product term A/B/C = i[2:0]
   always_comb begin
      d_word = '0;
      for (int i = 0; i < 8; i++) begin
         if (ctrl.minterm[i]) begin
            d_word = d_word
                   | ((i[2] ? a_shifted : ~a_shifted)
                    & (i[1] ? b_shifted : ~b_shifted)
                    & (i[0] ? c_word    : ~c_word));
         end
      end
   end

endmodule

### rtl/blitter_word_datapath.sv
// Top level of the blitter word datapath: register file, position counters,
// destination address and the result register. Uses bltw_pkg, bltw_word_logic.
//
// One transaction per clock is accepted and one result per transaction is
// returned: an input register feeds a single combinational pass (mask, shift,
// minterm, address add) into the result register. Only a stall on the result
// channel holds the input back. The counters, previous words and row pointer
// advance as each word moves from the input register to the result register.
// A new blit starts whenever both counters are zero, which clears the previous
// words and loads the row pointer from dest_start. Program the registers over
// the APB port only while no transaction is in flight.
module blitter_word_datapath (
   input  logic                clock,
   input  logic                reset,
   // input channel
   input  logic                req_valid,
   output logic                req_stall,
   input  bltw_pkg::req_type   req_data,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bltw_pkg::rsp_type   rsp_data,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   // Configuration registers
   logic [15:0] control_zero_ff;
   logic [15:0] control_one_ff;
   logic [15:0] first_mask_ff;
   logic [15:0] last_mask_ff;
   logic [15:0] blit_size_ff;
   logic [23:0] dest_start_ff;
   logic [15:0] dest_modulo_ff;

   // Pipeline registers
   logic                in_valid_ff;
   bltw_pkg::req_type   in_data_ff;
   logic                out_valid_ff;
   bltw_pkg::rsp_type   out_data_ff;
   bltw_pkg::rsp_type   out_data_in;

   // Blit state
   logic [5:0]  column_ff;
   logic [5:0]  column_in;
   logic [9:0]  row_ff;
   logic [9:0]  row_in;
   logic [15:0] prev_a_ff;
   logic [15:0] prev_b_ff;
   logic [23:0] row_ptr_ff;
   logic [23:0] row_ptr_in;

   logic                     advance;
   logic                     blit_start;
   logic                     last_col;
   logic                     last_row;
   logic                     descending;
   logic                     use_d;
   logic [6:0]               width;
   logic [10:0]              height;
   logic [15:0]              prev_a_eff;
   logic [15:0]              prev_b_eff;
   logic [23:0]              row_ptr_eff;
   logic [23:0]              col_offset;
   logic [23:0]              address;
   logic [23:0]              row_step;
   logic [24:0]              address_end;
   logic [15:0]              a_clipped;
   logic [15:0]              d_word;
   bltw_pkg::word_ctrl_type  word_ctrl;
   bltw_pkg::reg_index_type  csr_index;
   logic                     csr_write;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_index = bltw_pkg::reg_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         control_zero_ff <= '0;
         control_one_ff  <= '0;
         first_mask_ff   <= 16'hFFFF;
         last_mask_ff    <= 16'hFFFF;
         blit_size_ff    <= '0;
         dest_start_ff   <= '0;
         dest_modulo_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            bltw_pkg::REG_CONTROL_ZERO:    control_zero_ff <= pwdata[15:0];
            bltw_pkg::REG_CONTROL_ONE:     control_one_ff  <= pwdata[15:0];
            bltw_pkg::REG_FIRST_WORD_MASK: first_mask_ff   <= pwdata[15:0];
            bltw_pkg::REG_LAST_WORD_MASK:  last_mask_ff    <= pwdata[15:0];
            bltw_pkg::REG_BLIT_SIZE:       blit_size_ff    <= pwdata[15:0];
            bltw_pkg::REG_DEST_START:      dest_start_ff   <= pwdata[23:0];
            bltw_pkg::REG_DEST_MODULO:     dest_modulo_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      case (csr_index)
         bltw_pkg::REG_CONTROL_ZERO:    prdata = {16'h0, control_zero_ff};
         bltw_pkg::REG_CONTROL_ONE:     prdata = {16'h0, control_one_ff};
         bltw_pkg::REG_FIRST_WORD_MASK: prdata = {16'h0, first_mask_ff};
         bltw_pkg::REG_LAST_WORD_MASK:  prdata = {16'h0, last_mask_ff};
         bltw_pkg::REG_BLIT_SIZE:       prdata = {16'h0, blit_size_ff};
         bltw_pkg::REG_DEST_START:      prdata = {8'h0, dest_start_ff};
         bltw_pkg::REG_DEST_MODULO:     prdata = {16'h0, dest_modulo_ff};
         default:                       prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   // The word moves forward when the result slot is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ---------------- position and edge detection ----------------
   assign descending = control_one_ff[1];
   assign use_d      = control_zero_ff[8];
   assign width      = (blit_size_ff[5:0] == 6'd0) ? 7'd64 : {1'b0, blit_size_ff[5:0]};
   assign height     = (blit_size_ff[15:6] == 10'd0) ? 11'd1024 : {1'b0, blit_size_ff[15:6]};
   assign blit_start = (column_ff == 6'd0) && (row_ff == 10'd0);
   assign last_col   = {1'b0, column_ff} >= (width - 7'd1);
   assign last_row   = {1'b0, row_ff} >= (height - 11'd1);

   // Blit start clears the carried words and reloads the row pointer
   assign prev_a_eff  = blit_start ? 16'h0 : prev_a_ff;
   assign prev_b_eff  = blit_start ? 16'h0 : prev_b_ff;
   assign row_ptr_eff = blit_start ? {dest_start_ff[23:1], 1'b0} : row_ptr_ff;

   // ---------------- word logic ----------------
   always_comb begin
      word_ctrl.a_shift    = control_zero_ff[15:12];
      word_ctrl.b_shift    = control_one_ff[15:12];
      word_ctrl.descending = descending;
      word_ctrl.minterm    = control_zero_ff[7:0];
      word_ctrl.first_mask = first_mask_ff;
      word_ctrl.last_mask  = last_mask_ff;
      word_ctrl.first_col  = (column_ff == 6'd0);
      word_ctrl.last_col   = last_col;
   end

   bltw_word_logic u_word_logic (
      .ctrl      (word_ctrl),
      .a_word    (in_data_ff.a_word),
      .b_word    (in_data_ff.b_word),
      .c_word    (in_data_ff.c_word),
      .prev_a    (prev_a_eff),
      .prev_b    (prev_b_eff),
      .a_clipped (a_clipped),
      .d_word    (d_word)
   );

   // ---------------- destination address ----------------
   assign col_offset  = {17'h0, column_ff, 1'b0};
   assign address     = descending ? (row_ptr_eff - col_offset) : (row_ptr_eff + col_offset);
   assign address_end = {1'b0, address} + 25'd1;
   // Row step: sign-extended modulo plus twice the width
   assign row_step    = {{8{dest_modulo_ff[15]}}, dest_modulo_ff} + {16'h0, width, 1'b0};

   always_comb begin
      out_data_in.d_word       = d_word;
      out_data_in.dest_address = {address[23:1], 1'b0};
      out_data_in.write_enable = use_d && (address_end < 25'(bltw_pkg::MemoryBytes));
      out_data_in.last_word    = last_col && last_row;
   end

   // Next position and row pointer
   always_comb begin
      column_in  = column_ff + 6'd1;
      row_in     = row_ff;
      row_ptr_in = row_ptr_eff;
      if (last_col) begin
         column_in = 6'd0;
         row_in    = last_row ? 10'd0 : row_ff + 10'd1;
         if (use_d) begin
            row_ptr_in = descending ? (row_ptr_eff - row_step) : (row_ptr_eff + row_step);
            row_ptr_in[0] = 1'b0;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         column_ff    <= '0;
         row_ff       <= '0;
         prev_a_ff    <= '0;
         prev_b_ff    <= '0;
         row_ptr_ff   <= '0;
      end else begin
         // input register
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         // result register
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         // blit state moves with each word
         if (advance) begin
            column_ff  <= column_in;
            row_ff     <= row_in;
            prev_a_ff  <= a_clipped;
            prev_b_ff  <= in_data_ff.b_word;
            row_ptr_ff <= row_ptr_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule
